// ----- rtl/swerm_pkg.sv -----
`timescale 1ns / 1ps

package swerm_pkg;

  localparam int unsigned RING_DEPTH = 128;
  localparam int unsigned IDX_W      = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned WIN_W      = 32;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned SCALE_W    = 28;
  localparam int unsigned NUM_W      = (CNT_W + SCALE_W > RATE_W + 1) ?
                                       (CNT_W + SCALE_W) : (RATE_W + 1);
  localparam int unsigned DCNT_W     = $clog2(NUM_W + 1);

  localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(256000000);
  localparam logic [WIN_W-1:0]   WIN_RESET  = WIN_W'(1000000);

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef struct packed {
    logic tick;
    logic clear;
    logic capture;
    logic prep;
    logic check;
    logic walk;
    logic mul;
    logic div_step;
    logic load;
  } swerm_cmd_t;

  typedef struct packed {
    logic early;
    logic walk_done;
    logic div_done;
  } swerm_sts_t;

endpackage

// ----- rtl/swerm_ctrl.sv -----
`timescale 1ns / 1ps

module swerm_ctrl import swerm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  swerm_sts_t sts_i,
  output swerm_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_WALK,
    S_MUL,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.tick    = acc && (in_kind_i == KIND_TICK);
        cmd_o.clear   = acc && (in_kind_i == KIND_CLEAR);
        cmd_o.capture = acc && (in_kind_i == KIND_QUERY);
        if (cmd_o.capture) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.early ? S_OUT : S_WALK;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/swerm_dp.sv -----
`timescale 1ns / 1ps

module swerm_dp import swerm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WIN_W-1:0]   cfg_wdata_i,
  input  logic [TIME_W-1:0]  now_time_i,
  input  swerm_cmd_t         cmd_i,
  output swerm_sts_t         sts_o,
  output logic [RATE_W-1:0]  rate_q8_o,
  output logic [COUNT_W-1:0] window_count_o,
  output logic [WIN_W-1:0]   measured_span_o
);

  logic [TIME_W-1:0] mem [RING_DEPTH];

  logic [WIN_W-1:0]  win_q;
  logic [IDX_W-1:0]  wr_idx_q;
  logic              full_q;
  logic              started_q;
  logic [TIME_W-1:0] first_q;

  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] age_q;
  logic              neg_q;
  logic [TIME_W-1:0] thr_q;
  logic              thr_ok_q;
  logic              zero_q;
  logic [WIN_W-1:0]  span_q;

  logic [CNT_W-1:0]  iss_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              pend_q;
  logic [TIME_W-1:0] rd_q;

  logic [NUM_W-1:0]  quo_q;
  logic [WIN_W-1:0]  rem_q;
  logic [DCNT_W-1:0] dcnt_q;

  logic [RATE_W-1:0]  rate_q;
  logic [COUNT_W-1:0] count_q;
  logic [WIN_W-1:0]   mspan_q;

  logic [TIME_W-1:0] win_ext;
  logic [CNT_W-1:0]  stored;
  logic              older;
  logic              issue;
  logic [IDX_W-1:0]  rd_addr;
  logic [WIN_W:0]    shifted;
  logic [WIN_W+1:0]  diff;
  logic [RATE_W-1:0] rate_sat;
  logic [COUNT_W-1:0] count_sat;

  assign win_ext = TIME_W'(win_q);
  assign stored  = full_q ? CNT_W'(RING_DEPTH) : CNT_W'(wr_idx_q);
  assign older   = thr_ok_q && (rd_q <= thr_q);
  assign issue   = cmd_i.walk && (iss_q < stored) && !(pend_q && older);
  assign rd_addr = wr_idx_q - IDX_W'(1) - iss_q[IDX_W-1:0];

  assign sts_o.early     = !started_q || neg_q || (age_q < (win_ext >> 1));
  assign sts_o.walk_done = (pend_q && older) || (!pend_q && (iss_q == stored));
  assign sts_o.div_done  = (dcnt_q == DCNT_W'(NUM_W));

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, span_q};

  assign rate_sat  = (span_q == '0) ? '0 :
                     (quo_q[NUM_W-1:RATE_W] != '0) ? '1 : quo_q[RATE_W-1:0];
  assign count_sat = (cnt_q > CNT_W'(255)) ? COUNT_W'(255) : COUNT_W'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      mem[wr_idx_q] <= now_time_i;
    end
    if (issue) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= WIN_RESET;
      wr_idx_q  <= '0;
      full_q    <= 1'b0;
      started_q <= 1'b0;
      first_q   <= '0;
      pend_q    <= 1'b0;
      iss_q     <= '0;
      cnt_q     <= '0;
      dcnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      if (cmd_i.tick) begin
        if (!started_q) begin
          first_q   <= now_time_i;
          started_q <= 1'b1;
        end
        wr_idx_q <= wr_idx_q + IDX_W'(1);
        if (wr_idx_q == IDX_W'(RING_DEPTH - 1)) begin
          full_q <= 1'b1;
        end
      end
      if (cmd_i.clear) begin
        wr_idx_q  <= '0;
        full_q    <= 1'b0;
        started_q <= 1'b0;
        first_q   <= '0;
      end
      if (cmd_i.prep) begin
        iss_q  <= '0;
        cnt_q  <= '0;
        pend_q <= 1'b0;
      end
      if (cmd_i.walk) begin
        pend_q <= issue;
        if (issue) begin
          iss_q <= iss_q + CNT_W'(1);
        end
        if (pend_q && !older) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.mul) begin
        dcnt_q <= '0;
      end
      if (cmd_i.div_step && !sts_o.div_done) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q <= now_time_i;
    end
    if (cmd_i.prep) begin
      age_q    <= now_q - first_q;
      neg_q    <= now_q < first_q;
      thr_q    <= now_q - win_ext;
      thr_ok_q <= now_q >= win_ext;
    end
    if (cmd_i.check) begin
      zero_q <= sts_o.early;
      span_q <= (win_ext < age_q) ? win_q : age_q[WIN_W-1:0];
    end
    if (cmd_i.mul) begin
      quo_q <= NUM_W'(cnt_q) * NUM_W'(RATE_SCALE);
      rem_q <= '0;
    end
    if (cmd_i.div_step && !sts_o.div_done) begin
      if (!diff[WIN_W+1]) begin
        rem_q <= diff[WIN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[WIN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd_i.load) begin
      if (zero_q) begin
        rate_q  <= '0;
        count_q <= '0;
        mspan_q <= '0;
      end else begin
        rate_q  <= rate_sat;
        count_q <= count_sat;
        mspan_q <= span_q;
      end
    end
  end

  assign rate_q8_o       = rate_q;
  assign window_count_o  = count_q;
  assign measured_span_o = mspan_q;

endmodule

// ----- rtl/sliding_window_event_rate_meter_unit.sv -----
`timescale 1ns / 1ps
// Ticks and clears are accepted back to back while no query is in progress.
// A query is captured, then steps through prep and check; unless it is early, it walks the
// stored ring entries (up to 128, one per cycle) and then runs the multiply and the
// bit-serial divider before its result word is loaded. An early query skips the walk and
// the divide. No new word is taken until the result word has been loaded for output.
// Reset is asynchronous and active low; it clears control state only.
module sliding_window_event_rate_meter_unit import swerm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // now_time[47:0]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // rate_q8[31:0], window_count[39:32],
                                     // measured_span[71:40]
);

  swerm_cmd_t cmd;
  swerm_sts_t sts;

  swerm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swerm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .now_time_i      (s_axis_tdata),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rate_q8_o       (m_axis_tdata[31:0]),
    .window_count_o  (m_axis_tdata[39:32]),
    .measured_span_o (m_axis_tdata[71:40])
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import swerm_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned PHASE_WORDS = 138;
  localparam int unsigned SCRIPT_ROWS = 24;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [31:0] rate;
    logic [7:0]  count;
    logic [31:0] span;
  } reading_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] stamp;
    logic        pinned;
    reading_t    want;
  } script_row_t;

  localparam reading_t QUIET = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  idle_mode_e idle_mode = IDLE_NONE;
  int unsigned errors = 0;

  logic [TIME_W-1:0] tick_times [RING_DEPTH];
  logic [IDX_W-1:0]  wr_idx = '0;
  logic              wrapped = 1'b0;
  logic [TIME_W-1:0] start_time = '0;
  logic              running = 1'b0;
  logic [WIN_W-1:0]  window_us = WIN_RESET;

  reading_t pending_readings [$];

  logic [47:0] cur_time = '0;
  int unsigned ticks_left = 0;

  script_row_t script [SCRIPT_ROWS] = '{
    '{KIND_QUERY, 48'd0,             1'b1, '{32'd0, 8'd0, 32'd0}},
    '{KIND_NONE,  48'd5,             1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_TICK,  48'd100,           1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_QUERY, 48'd200,           1'b1, '{32'd0, 8'd0, 32'd0}},
    '{KIND_QUERY, 48'd500099,        1'b1, '{32'd0, 8'd0, 32'd0}},
    '{KIND_QUERY, 48'd500100,        1'b1, '{32'd512, 8'd1, 32'd500000}},
    '{KIND_TICK,  48'd600000,        1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_TICK,  48'd700000,        1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_QUERY, 48'd1000100,       1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_QUERY, 48'd1700000,       1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_CLEAR, 48'd1800000,       1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_QUERY, 48'd1900000,       1'b1, '{32'd0, 8'd0, 32'd0}},
    '{KIND_TICK,  48'd2000000,       1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_QUERY, 48'd1000000,       1'b1, '{32'd0, 8'd0, 32'd0}},
    '{KIND_QUERY, 48'd2600000,       1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_NONE,  48'hFFFF_FFFF_FFFF, 1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_CLEAR, 48'd0,             1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_TICK,  48'd0,             1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_QUERY, 48'd0,             1'b1, '{32'd0, 8'd0, 32'd0}},
    '{KIND_CLEAR, 48'hFFFF_FFF0_0000, 1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_TICK,  48'hFFFF_FFF0_0000, 1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_TICK,  48'hFFFF_FFFF_F000, 1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_QUERY, 48'hFFFF_FFFF_FFFF, 1'b0, '{32'd0, 8'd0, 32'd0}},
    '{KIND_CLEAR, 48'hFFFF_FFFF_FFFF, 1'b0, '{32'd0, 8'd0, 32'd0}}
  };

  sliding_window_event_rate_meter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Returns 1 when the word yields a rate reading.
  function automatic bit advance_meter(input logic [1:0] kind, input logic [47:0] now,
                                       output reading_t r);
    int unsigned held;
    int unsigned hits;
    int unsigned slot;
    logic [63:0] win;
    logic [63:0] age;
    logic [63:0] span;
    logic [63:0] quot;
    r = QUIET;
    win = 64'(window_us);
    case (kind)
      KIND_TICK: begin
        if (!running) begin
          start_time = now;
          running = 1'b1;
        end
        tick_times[wr_idx] = now;
        wr_idx = wr_idx + IDX_W'(1);
        if (wr_idx == '0) begin
          wrapped = 1'b1;
        end
        return 1'b0;
      end
      KIND_CLEAR: begin
        wr_idx = '0;
        wrapped = 1'b0;
        start_time = '0;
        running = 1'b0;
        return 1'b0;
      end
      KIND_QUERY: begin
        if (!running || now < start_time) begin
          return 1'b1;
        end
        age = 64'(now - start_time);
        if (age < (win >> 1)) begin
          return 1'b1;
        end
        held = wrapped ? RING_DEPTH : 32'(wr_idx);
        hits = 0;
        for (int i = 0; i < held; i++) begin
          slot = (32'(wr_idx) + RING_DEPTH - 1 - i) % RING_DEPTH;
          if (64'(tick_times[slot]) + win <= 64'(now)) begin
            break;
          end
          hits++;
        end
        span = (win < age) ? win : age;
        quot = (span == 0) ? 64'd0 : (64'(hits) * 64'd256000000) / span;
        r.rate = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
        r.count = (hits > 255) ? 8'hFF : 8'(hits);
        r.span = span[31:0];
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [47:0] time_step();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) begin
      return '0;
    end
    if (roll < 75) begin
      return 48'($urandom_range(window_us >> 4));
    end
    if (roll < 95) begin
      return 48'($urandom_range(window_us));
    end
    return 48'(window_us) + 48'($urandom_range(window_us)) + 48'($urandom_range(window_us));
  endfunction

  task automatic send_word(input logic [1:0] kind, input logic [47:0] now, input bit pinned,
                           input reading_t want);
    reading_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= now;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    if (advance_meter(kind, now, predicted)) begin
      pending_readings.push_back(pinned ? want : predicted);
    end
    while (((idle_mode == IDLE_SEND) && ($urandom_range(99) < 57)) ||
           ((idle_mode == IDLE_BOTH) && ($urandom_range(99) < 34))) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain_readings();
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [31:0] value);
    drain_readings();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    window_us = value;
  endtask

  // Runs of ticks and queries between clears; about a third of the runs wrap the ring.
  task automatic run_random(input int unsigned budget);
    int unsigned sent;
    int unsigned roll;
    sent = 0;
    while (sent < budget) begin
      roll = $urandom_range(99);
      if (ticks_left == 0) begin
        send_word(KIND_CLEAR, cur_time, 1'b0, QUIET);
        sent++;
        ticks_left = ($urandom_range(99) < 35) ? $urandom_range(180, 130) : $urandom_range(30, 1);
        if ($urandom_range(2) == 0) begin
          cur_time = 48'({$urandom(), $urandom()});
        end
      end else if (roll < 3) begin
        send_word(KIND_NONE, 48'({$urandom(), $urandom()}), 1'b0, QUIET);
      end else if (roll < 5) begin
        send_word(KIND_QUERY, cur_time - time_step(), 1'b0, QUIET);
        sent++;
      end else if (roll < 63) begin
        cur_time = cur_time + time_step();
        send_word(KIND_TICK, cur_time, 1'b0, QUIET);
        ticks_left--;
        sent++;
      end else begin
        cur_time = cur_time + time_step();
        send_word(KIND_QUERY, cur_time, 1'b0, QUIET);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    reading_t got;
    reading_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.rate = m_axis_tdata[31:0];
      got.count = m_axis_tdata[39:32];
      got.span = m_axis_tdata[71:40];
      if (pending_readings.size() == 0) begin
        $error("unexpected result word: rate_q8 %0d window_count %0d measured_span %0d",
               got.rate, got.count, got.span);
        errors++;
      end else begin
        exp_r = pending_readings.pop_front();
        if (got.rate !== exp_r.rate) begin
          $error("rate_q8: expected %0d, got %0d", exp_r.rate, got.rate);
          errors++;
        end
        if (got.count !== exp_r.count) begin
          $error("window_count: expected %0d, got %0d", exp_r.count, got.count);
          errors++;
        end
        if (got.span !== exp_r.span) begin
          $error("measured_span: expected %0d, got %0d", exp_r.span, got.span);
          errors++;
        end
      end
    end
    if (idle_mode == IDLE_RECV) begin
      m_axis_tready <= ($urandom_range(99) >= 57);
    end else if (idle_mode == IDLE_BOTH) begin
      m_axis_tready <= ($urandom_range(99) >= 34);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      send_word(script[i].kind, script[i].stamp, script[i].pinned, script[i].want);
    end
    cur_time = 48'($urandom_range(1000));
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        1: set_window(32'd2);
        2: set_window(32'hFFFF_FFFF);
        3: set_window(32'd1000);
        4: set_window($urandom_range(32'hFFFF_FFFF, 2));
        5: set_window(32'd3);
        6: set_window($urandom_range(100000, 2));
        7: set_window($urandom_range(5000, 2));
        default: ;
      endcase
      idle_mode = idle_mode_e'(phase % 4);
      run_random(PHASE_WORDS);
    end
    drain_readings();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
